// ===== design/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
// No dependencies; imported by the walk engine and the top level.
`timescale 1ns / 1ps

package wgm_pkg;

	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	typedef struct packed {
		logic       func;
		logic [7:0] symbol;
	} wgm_sym_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} wgm_res_t;

	// Start command from the loader to the walk engine.
	typedef struct packed {
		logic go;
		logic ovf;
	} wgm_start_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_READ,
		WS_EVAL,
		WS_DONE
	} wgm_state_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
		logic [7:0] r;
		r = c;
		if (fold_en && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r = c - CASE_DELTA;
		end
		return r;
	endfunction

endpackage

// ===== design/wgm_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/wgm_walk.sv =====
// Glob walk engine: greedy single-backtrack match over the pattern and text RAMs.
// Depends on wgm_pkg. Drives the RAM read ports; each walk step is a RAM read, then a compare.
`timescale 1ns / 1ps

module wgm_walk #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT = 64,
	localparam int PLW = $clog2(MAX_PATTERN + 1),
	localparam int TLW = $clog2(MAX_TEXT + 1),
	localparam int PAW = $clog2(MAX_PATTERN),
	localparam int TAW = $clog2(MAX_TEXT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wgm_pkg::wgm_start_t start,
	input  logic [PLW-1:0]      pat_len,
	input  logic [TLW-1:0]      txt_len,
	input  logic                fold_en,
	output logic                busy,
	output logic                done,
	output wgm_pkg::wgm_res_t   res,
	input  logic                take,
	output logic                pat_re,
	output logic [PAW-1:0]      pat_raddr,
	input  logic [7:0]          pat_rdata,
	output logic                txt_re,
	output logic [TAW-1:0]      txt_raddr,
	input  logic [7:0]          txt_rdata
);

	import wgm_pkg::*;

	// star_s can run one past the text length
	localparam int TCW = $clog2(MAX_TEXT + 2);

	wgm_state_t state_q, state_d;

	logic [PLW-1:0] plen_q, w_q, w_d, sw_q, sw_d;
	logic [TLW-1:0] tlen_q;
	logic [TCW-1:0] s_q, s_d, ss_q, ss_d;
	logic           have_q, have_d, tail_q, tail_d;
	logic           hit_q, ovf_q;
	logic [7:0]     pc, tc;
	logic           fin, hit;

	assign pc = (w_q < plen_q) ? fold_char(pat_rdata, fold_en) : 8'h00;
	assign tc = (s_q < TCW'(tlen_q)) ? fold_char(txt_rdata, fold_en) : 8'h00;

	// One step of the walk on the characters just read.
	always_comb begin
		w_d    = w_q;
		s_d    = s_q;
		sw_d   = sw_q;
		ss_d   = ss_q;
		have_d = have_q;
		tail_d = tail_q;
		fin    = 1'b0;
		hit    = 1'b0;
		if (tail_q || tc == 8'h00) begin
			// text used up: only trailing stars may remain
			tail_d = 1'b1;
			if (pc == CH_STAR) begin
				w_d = w_q + PLW'(1);
			end else begin
				fin = 1'b1;
				hit = (pc == 8'h00);
			end
		end else if (pc == CH_STAR) begin
			if (w_q + PLW'(1) >= plen_q) begin
				fin = 1'b1;
				hit = 1'b1;
			end else begin
				w_d    = w_q + PLW'(1);
				sw_d   = w_q + PLW'(1);
				ss_d   = s_q + TCW'(1);
				have_d = 1'b1;
			end
		end else if (pc == tc || pc == CH_QUEST) begin
			w_d = w_q + PLW'(1);
			s_d = s_q + TCW'(1);
		end else if (!have_q) begin
			fin = 1'b1;
		end else begin
			w_d  = sw_q;
			s_d  = ss_q;
			ss_d = ss_q + TCW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			WS_IDLE: begin
				if (start.go) begin
					state_d = start.ovf ? WS_DONE : WS_READ;
				end
			end
			WS_READ: state_d = WS_EVAL;
			WS_EVAL: state_d = fin ? WS_DONE : WS_READ;
			WS_DONE: begin
				if (take) begin
					state_d = WS_IDLE;
				end
			end
			default: state_d = WS_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != WS_IDLE);
		done = (state_q == WS_DONE);
		pat_re = (state_q == WS_READ);
		txt_re = (state_q == WS_READ);
		res.matched = hit_q;
		res.overflow = ovf_q;
	end

	assign pat_raddr = w_q[PAW-1:0];
	assign txt_raddr = s_q[TAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == WS_IDLE && start.go) begin
			plen_q <= pat_len;
			tlen_q <= txt_len;
			ovf_q  <= start.ovf;
			hit_q  <= 1'b0;
			w_q    <= '0;
			s_q    <= '0;
			sw_q   <= '0;
			ss_q   <= '0;
			have_q <= 1'b0;
			tail_q <= 1'b0;
		end else if (state_q == WS_EVAL) begin
			w_q    <= w_d;
			s_q    <= s_d;
			sw_q   <= sw_d;
			ss_q   <= ss_d;
			have_q <= have_d;
			tail_q <= tail_d;
			if (fin) begin
				hit_q <= hit;
			end
		end
	end

endmodule

// ===== design/wildcard_glob_matcher.sv =====
// Wildcard glob matcher top level: string loader, pattern/text RAMs, result register.
// Depends on wgm_pkg, wgm_ram and wgm_walk.
//
//   channel | dir | handshake            | beat
//   sym     | in  | sym_valid/sym_stall  | wgm_sym_t {func, symbol}
//   res     | out | res_valid/res_stall  | wgm_res_t {matched, overflow}
//   cfg     | in  | cfg_we               | cfg_wdata = case_insensitive
//
// Bytes are taken while sym_stall is low. A text terminator starts the walk;
// sym_stall stays high until its result is in the output register.
// Each walk step is a RAM read, then a compare; an overflowed string skips
// the walk and goes straight to its result.
// Reset clears lengths and flags; store contents are not cleared.
`timescale 1ns / 1ps

module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_stall,
	input  wgm_pkg::wgm_sym_t sym_data,
	output logic              res_valid,
	input  logic              res_stall,
	output wgm_pkg::wgm_res_t res_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	import wgm_pkg::*;

	localparam int PLW = $clog2(MAX_PATTERN + 1);
	localparam int TLW = $clog2(MAX_TEXT + 1);
	localparam int PAW = $clog2(MAX_PATTERN);
	localparam int TAW = $clog2(MAX_TEXT);

	logic [PLW-1:0] pat_len_q, p_base;
	logic           pat_done_q, pat_ovf_q, p_ovf_base;
	logic [TLW-1:0] txt_len_q;
	logic           txt_ovf_q;
	logic           ci_q;
	logic           res_valid_q;
	wgm_res_t       res_q;

	logic           acc, p_acc, t_acc, nz, p_full, t_full, pat_we, txt_we;
	wgm_start_t     start;
	logic           walk_busy, walk_done, take;
	wgm_res_t       walk_res;
	logic           pat_re, txt_re;
	logic [PAW-1:0] pat_raddr;
	logic [TAW-1:0] txt_raddr;
	logic [7:0]     pat_rdata, txt_rdata;

	assign sym_stall = walk_busy;
	assign acc   = sym_valid && !sym_stall;
	assign p_acc = acc && !sym_data.func;
	assign t_acc = acc && sym_data.func;
	assign nz    = (sym_data.symbol != 8'h00);

	// first byte after a finished pattern starts a new one
	assign p_base     = pat_done_q ? '0 : pat_len_q;
	assign p_ovf_base = pat_done_q ? 1'b0 : pat_ovf_q;
	assign p_full     = (p_base == PLW'(MAX_PATTERN));
	assign t_full     = (txt_len_q == TLW'(MAX_TEXT));
	assign pat_we     = p_acc && nz && !p_full;
	assign txt_we     = t_acc && nz && !t_full;

	assign start.go  = t_acc && !nz;
	assign start.ovf = pat_ovf_q || txt_ovf_q;

	assign take = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q   <= '0;
			pat_done_q  <= 1'b1;
			pat_ovf_q   <= 1'b0;
			txt_len_q   <= '0;
			txt_ovf_q   <= 1'b0;
			ci_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ci_q <= cfg_wdata;
			end
			if (p_acc) begin
				pat_done_q <= !nz;
				pat_len_q  <= p_base + PLW'(pat_we);
				pat_ovf_q  <= p_ovf_base || (nz && p_full);
			end
			if (start.go) begin
				txt_len_q <= '0;
				txt_ovf_q <= 1'b0;
			end else if (t_acc) begin
				txt_len_q <= txt_len_q + TLW'(txt_we);
				txt_ovf_q <= txt_ovf_q || t_full;
			end
			if (walk_done && take) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_done && take) begin
			res_q <= walk_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	wgm_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(p_base[PAW-1:0]),
		.wdata(sym_data.symbol),
		.re   (pat_re),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	wgm_ram #(
		.WIDTH(8),
		.DEPTH(MAX_TEXT)
	) u_txt_ram (
		.clk  (clk),
		.we   (txt_we),
		.waddr(txt_len_q[TAW-1:0]),
		.wdata(sym_data.symbol),
		.re   (txt_re),
		.raddr(txt_raddr),
		.rdata(txt_rdata)
	);

	wgm_walk #(
		.MAX_PATTERN(MAX_PATTERN),
		.MAX_TEXT   (MAX_TEXT)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.pat_len  (pat_len_q),
		.txt_len  (txt_len_q),
		.fold_en  (ci_q),
		.busy     (walk_busy),
		.done     (walk_done),
		.res      (walk_res),
		.take     (take),
		.pat_re   (pat_re),
		.pat_raddr(pat_raddr),
		.pat_rdata(pat_rdata),
		.txt_re   (txt_re),
		.txt_raddr(txt_raddr),
		.txt_rdata(txt_rdata)
	);

endmodule

// ===== tb/wgm_scoreboard.sv =====
// Scoreboard for the wildcard glob matcher: mirrors pattern/text loading, predicts
// the verdict of each text and compares it with the result beats.
// Depends on wgm_pkg; also holds the small wgm_tb_pkg shared with the testbench top.
`timescale 1ns / 1ps

package wgm_tb_pkg;
	localparam logic       FN_PATTERN    = 1'b0;
	localparam logic       FN_TEXT       = 1'b1;
	localparam logic [7:0] END_OF_STRING = 8'h00;
endpackage

module wgm_scoreboard #(
	parameter int PAT_DEPTH = 64,
	parameter int TXT_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	input  logic              sym_stall,
	input  wgm_pkg::wgm_sym_t sym_data,
	input  logic              res_valid,
	input  logic              res_stall,
	input  wgm_pkg::wgm_res_t res_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output int                errors,
	output int                verdicts_due,
	output int                results_seen,
	output int                hits,
	output int                overflows
);
	import wgm_pkg::*;
	import wgm_tb_pkg::*;

	logic [7:0] pat_mem [PAT_DEPTH];
	int         pat_len = 0;
	logic       pat_done = 1'b1;
	logic       pat_ovf = 1'b0;
	logic [7:0] txt_mem [TXT_DEPTH];
	int         txt_len = 0;
	logic       txt_ovf = 1'b0;
	logic       fold_en = 1'b0;
	wgm_res_t   verdict_q [$];
	int         err_cnt = 0;
	int         seen_cnt = 0;
	int         hit_cnt = 0;
	int         ovf_cnt = 0;

	function automatic logic [7:0] upcase(logic [7:0] c);
		if (fold_en && c >= CH_LOWER_A && c <= CH_LOWER_Z)
			return c - CASE_DELTA;
		return c;
	endfunction

	// Past the end of a string both stores read as a terminator.
	function automatic logic [7:0] pat_char(int i);
		return (i < pat_len) ? upcase(pat_mem[i]) : END_OF_STRING;
	endfunction

	function automatic logic [7:0] txt_char(int i);
		return (i < txt_len) ? upcase(txt_mem[i]) : END_OF_STRING;
	endfunction

	// Greedy glob walk with one backtrack point at the most recent star.
	function automatic logic glob_hit();
		int         w;
		int         s;
		int         star_w;
		int         star_s;
		logic       starred;
		logic [7:0] pc;
		w = 0;
		s = 0;
		star_w = 0;
		star_s = 0;
		starred = 1'b0;
		while (txt_char(s) != END_OF_STRING && pat_char(w) != CH_STAR) begin
			if (pat_char(w) != txt_char(s) && pat_char(w) != CH_QUEST)
				return 1'b0;
			w++;
			s++;
		end
		while (txt_char(s) != END_OF_STRING) begin
			pc = pat_char(w);
			if (pc == CH_STAR) begin
				w++;
				if (pat_char(w) == END_OF_STRING)
					return 1'b1;
				star_w = w;
				star_s = s + 1;
				starred = 1'b1;
			end else if (pc == txt_char(s) || pc == CH_QUEST) begin
				w++;
				s++;
			end else begin
				if (!starred)
					return 1'b0;
				w = star_w;
				s = star_s;
				star_s++;
			end
		end
		while (pat_char(w) == CH_STAR)
			w++;
		return pat_char(w) == END_OF_STRING;
	endfunction

	task automatic load_symbol(wgm_sym_t b);
		wgm_res_t v;
		if (b.func == FN_PATTERN) begin
			// first byte after a finished pattern starts a new one
			if (pat_done) begin
				pat_len = 0;
				pat_ovf = 1'b0;
				pat_done = 1'b0;
			end
			if (b.symbol == END_OF_STRING) begin
				pat_done = 1'b1;
			end else if (pat_len < PAT_DEPTH) begin
				pat_mem[pat_len] = b.symbol;
				pat_len++;
			end else begin
				pat_ovf = 1'b1;
			end
		end else if (b.symbol != END_OF_STRING) begin
			if (txt_len < TXT_DEPTH) begin
				txt_mem[txt_len] = b.symbol;
				txt_len++;
			end else begin
				txt_ovf = 1'b1;
			end
		end else begin
			v.overflow = pat_ovf || txt_ovf;
			v.matched = v.overflow ? 1'b0 : glob_hit();
			verdict_q.push_back(v);
			txt_len = 0;
			txt_ovf = 1'b0;
		end
	endtask

	task automatic check_result(wgm_res_t got);
		wgm_res_t want;
		seen_cnt++;
		if (got.matched)
			hit_cnt++;
		if (got.overflow)
			ovf_cnt++;
		if (verdict_q.size() == 0) begin
			err_cnt++;
			$display("%0t: result beat with none expected: matched=%0b overflow=%0b",
				$time, got.matched, got.overflow);
			return;
		end
		want = verdict_q.pop_front();
		if (got.matched !== want.matched) begin
			err_cnt++;
			$display("%0t: matched mismatch: expected %0b, actual %0b",
				$time, want.matched, got.matched);
		end
		if (got.overflow !== want.overflow) begin
			err_cnt++;
			$display("%0t: overflow mismatch: expected %0b, actual %0b",
				$time, want.overflow, got.overflow);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len = 0;
			pat_done = 1'b1;
			pat_ovf = 1'b0;
			txt_len = 0;
			txt_ovf = 1'b0;
			fold_en = 1'b0;
			verdict_q.delete();
		end else begin
			// a result beat can never belong to a terminator taken on the same edge
			if (res_valid && !res_stall)
				check_result(res_data);
			if (sym_valid && !sym_stall)
				load_symbol(sym_data);
			if (cfg_we)
				fold_en = cfg_wdata;
		end
		errors <= err_cnt;
		verdicts_due <= verdict_q.size();
		results_seen <= seen_cnt;
		hits <= hit_cnt;
		overflows <= ovf_cnt;
	end

endmodule

// ===== tb/wildcard_glob_matcher_test.sv =====
// Testbench top for the wildcard glob matcher: clock, reset, symbol stimulus,
// result stall pattern and the final verdict.
// Depends on wgm_pkg, wgm_tb_pkg, wgm_scoreboard and the wildcard_glob_matcher RTL.
`timescale 1ns / 1ps

module wildcard_glob_matcher_test;
	import wgm_pkg::*;
	import wgm_tb_pkg::*;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int ITEM_TARGET  = 1700;
	localparam int PHASES       = 6;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     sym_valid = 1'b0;
	logic     sym_stall;
	wgm_sym_t sym_data = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	wgm_res_t res_data;
	logic     cfg_we = 1'b0;
	logic     cfg_wdata = 1'b0;

	int errors;
	int verdicts_due;
	int results_seen;
	int hits;
	int overflows;

	int         beats_sent = 0;
	int         cycle_cnt = 0;
	int         burst_left = 0;
	int         cfg_writes = 0;
	logic       random_phase = 1'b0;
	logic [7:0] line_buf [$];
	logic [7:0] cur_pat [$];
	logic [7:0] letters [4] = '{"a", "b", "A", "B"};

	always #10 clk = ~clk;

	wildcard_glob_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_data  (sym_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	wgm_scoreboard sb (
		.clk          (clk),
		.arst_n       (arst_n),
		.sym_valid    (sym_valid),
		.sym_stall    (sym_stall),
		.sym_data     (sym_data),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_data     (res_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.errors       (errors),
		.verdicts_due (verdicts_due),
		.results_seen (results_seen),
		.hits         (hits),
		.overflows    (overflows)
	);

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 19) < 17)
			return letters[$urandom_range(0, 3)];
		return any_char();
	endfunction

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11)
			return letters[$urandom_range(0, 3)];
		if (r < 16)
			return CH_STAR;
		if (r < 19)
			return CH_QUEST;
		return any_char();
	endfunction

	function automatic logic [7:0] swap_case(logic [7:0] c);
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			return c - CASE_DELTA;
		if (c >= "A" && c <= "Z")
			return c + CASE_DELTA;
		return c;
	endfunction

	// One beat on the symbol channel; bursts of random length with random gaps.
	task automatic send_beat(logic f, logic [7:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sym_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		sym_valid <= 1'b1;
		sym_data <= '{func: f, symbol: s};
		@(posedge clk);
		while (sym_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_line(logic f, logic terminate);
		foreach (line_buf[i])
			send_beat(f, line_buf[i]);
		if (terminate)
			send_beat(f, END_OF_STRING);
	endtask

	// Drain everything in flight, then write the case-fold register.
	task automatic set_case_fold(logic v);
		sym_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	task automatic build_pattern(int n);
		cur_pat.delete();
		repeat (n) cur_pat.push_back(pattern_char());
	endtask

	// Text that mostly fits the current pattern, sometimes with one edit.
	task automatic build_text(int seq);
		int n;
		line_buf.delete();
		foreach (cur_pat[i]) begin
			if (cur_pat[i] == CH_STAR) begin
				repeat ($urandom_range(0, 3)) line_buf.push_back(text_char());
			end else if (cur_pat[i] == CH_QUEST) begin
				line_buf.push_back(text_char());
			end else begin
				line_buf.push_back(($urandom_range(0, 3) == 0) ? swap_case(cur_pat[i])
					: cur_pat[i]);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					if (line_buf.size() > 0)
						line_buf[$urandom_range(0, line_buf.size() - 1)] = text_char();
				end
				1: begin
					if (line_buf.size() > 0)
						line_buf.delete($urandom_range(0, line_buf.size() - 1));
				end
				default: begin
					line_buf.push_back(text_char());
				end
			endcase
		end
		// every so often a text around the store size
		if (seq % 16 == 11) begin
			n = $urandom_range(62, 70);
			while (line_buf.size() < n)
				line_buf.push_back(text_char());
		end
	endtask

	task automatic run_case(int seq);
		int r;
		r = $urandom_range(0, 99);
		if (seq % 16 == 3) begin
			build_pattern($urandom_range(40, 70));
			line_buf = cur_pat;
			send_line(FN_PATTERN, 1'b1);
		end else if (r < 30) begin
			build_pattern($urandom_range(0, 8));
			line_buf = cur_pat;
			send_line(FN_PATTERN, 1'b1);
		end else if (r < 36) begin
			// text arrives while the pattern is still open
			build_pattern($urandom_range(1, 6));
			line_buf = cur_pat;
			send_line(FN_PATTERN, 1'b0);
			build_text(seq);
			send_line(FN_TEXT, 1'b1);
			send_beat(FN_PATTERN, END_OF_STRING);
		end else if (r < 40) begin
			line_buf.delete();
			repeat ($urandom_range(0, 10)) line_buf.push_back(any_char());
			send_line(FN_TEXT, 1'b1);
		end else if (r < 43) begin
			cur_pat.delete();
			send_beat(FN_PATTERN, END_OF_STRING);
		end
		build_text(seq);
		send_line(FN_TEXT, 1'b1);
	endtask

	initial begin : stimulus
		int seq;
		int phase;
		seq = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty text against the empty pattern left by reset, then a short text
		send_beat(FN_TEXT, END_OF_STRING);
		line_buf = {"a"};
		send_line(FN_TEXT, 1'b1);
		// lone star against an empty text
		line_buf = {CH_STAR};
		send_line(FN_PATTERN, 1'b1);
		send_beat(FN_TEXT, END_OF_STRING);
		line_buf = {"a", CH_QUEST, "c", CH_STAR};
		send_line(FN_PATTERN, 1'b1);
		line_buf = {"a", "b", "c", 8'hFF};
		send_line(FN_TEXT, 1'b1);
		// bare terminator loads the empty pattern
		send_beat(FN_PATTERN, END_OF_STRING);
		send_beat(FN_TEXT, END_OF_STRING);
		// text while the pattern is half loaded, then the pattern goes on
		send_beat(FN_PATTERN, "x");
		line_buf = {"x"};
		send_line(FN_TEXT, 1'b1);
		line_buf = {"y"};
		send_line(FN_PATTERN, 1'b1);
		line_buf = {"x", "Y"};
		send_line(FN_TEXT, 1'b1);
		set_case_fold(1'b1);
		send_line(FN_TEXT, 1'b1);

		random_phase <= 1'b1;
		for (phase = 0; phase < PHASES; phase++) begin
			set_case_fold(phase[0]);
			while (beats_sent < (phase + 1) * ITEM_TARGET / PHASES) begin
				run_case(seq);
				seq++;
			end
		end

		sym_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Run covered %0d symbol beats in %0d cases and %0d register writes.",
			beats_sent, seq, cfg_writes);
		$display("Results checked: %0d (%0d matched, %0d overflowed).",
			results_seen, hits, overflows);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result stall pattern, with one long hold-off once random traffic is running.
	initial begin : result_sink
		int   mode_left;
		int   stall_pct;
		int   hold_left;
		int   hold_delay;
		logic held;
		mode_left = 0;
		stall_pct = 0;
		hold_left = 0;
		hold_delay = 300;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (random_phase && !held)
				hold_delay--;
			if (hold_delay == 0 && !held) begin
				held = 1'b1;
				hold_left = 800;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(10, 150);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				mode_left--;
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
				verdicts_due);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
